// File: rtl/arqs_pkg.sv
// Shared types, command codes, status codes and cell select codes of the ready queue.
package arqs_pkg;

   typedef struct packed {
      logic [7:0] tag;
      logic       prio;
      logic [7:0] score;
   } entry_type;

   localparam logic [2:0] CMD_ADD_TAIL  = 3'd0;
   localparam logic [2:0] CMD_ADD_HEAD  = 3'd1;
   localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
   localparam logic [2:0] CMD_POP_SHORT = 3'd3;
   localparam logic [2:0] CMD_AGE       = 3'd4;
   localparam logic [2:0] CMD_PROMOTE   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   localparam logic [2:0] SEL_HOLD  = 3'd0;
   localparam logic [2:0] SEL_NEW   = 3'd1;
   localparam logic [2:0] SEL_LEFT  = 3'd2;
   localparam logic [2:0] SEL_RIGHT = 3'd3;
   localparam logic [2:0] SEL_AGE   = 3'd4;

   typedef struct packed {
      logic [2:0] sel;
      logic       occupied;
   } cell_ctl_type;

   // True when entry a must be ordered after entry b.
   function automatic logic goes_after(input entry_type a, input entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = b.prio;
      end else begin
         result = a.score > b.score;
      end
      return result;
   endfunction

endpackage

// File: rtl/arqs_cell.sv
// One queue cell: holds an entry and one stage of the minimum and first-match chains.
module arqs_cell (
   input  logic                  clock,
   input  arqs_pkg::cell_ctl_type ctl,
   input  arqs_pkg::entry_type   new_entry,
   input  arqs_pkg::entry_type   left_entry,
   input  arqs_pkg::entry_type   right_entry,
   input  logic [7:0]            target_score,
   input  logic [7:0]            min_in,
   input  logic                  seen_in,
   output arqs_pkg::entry_type   entry,
   output logic [7:0]            min_out,
   output logic                  hit_out,
   output logic                  before_out
);
   import arqs_pkg::*;

   entry_type  entry_ff;
   entry_type  entry_in;
   logic [7:0] min_ff;
   logic [7:0] min_in_val;
   logic       before_ff;
   logic       match;

   assign match      = ctl.occupied && (entry_ff.score == target_score);
   assign hit_out    = before_ff | match;
   assign before_out = before_ff;
   assign entry      = entry_ff;
   assign min_out    = min_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.sel)
         SEL_HOLD:  entry_in = entry_ff;
         SEL_NEW:   entry_in = new_entry;
         SEL_LEFT:  entry_in = left_entry;
         SEL_RIGHT: entry_in = right_entry;
         SEL_AGE: begin
            if (entry_ff.score != 8'd0) begin
               entry_in.score = entry_ff.score - 8'd1;
            end
         end
         default:   entry_in = entry_ff;
      endcase
   end

   always_comb begin
      min_in_val = min_in;
      if (ctl.occupied && (entry_ff.score < min_in)) begin
         min_in_val = entry_ff.score;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      min_ff    <= min_in_val;
      before_ff <= seen_in;
   end

endmodule

// File: rtl/aging_ready_queue_scheduler_top.sv
// Top level of the aging shortest-job-first ready queue built from a row of cells.
//
//   Channel   Direction   Beat contents
//   req_      in          command, entry tag, priority flag, score
//   rsp_      out         popped entry, least score, empty flag, status
//
// A command runs an execute state and a chain scan before its result beat; pop shortest
// on a nonempty queue sorts first and promote scans first. The minimum and first-match
// chains move one cell per cycle and set the settle time; pop shortest runs QUEUE_DEPTH
// odd-even sort phases.
// The result sits in an output register, so a new beat is taken while it waits.
// Reset is synchronous and empties the queue; the entry storage itself is not cleared.
module aging_ready_queue_scheduler_top #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_entry_tag,
   input  logic       req_entry_priority,
   input  logic [7:0] req_score_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_popped_valid,
   output logic [7:0] rsp_popped_tag,
   output logic       rsp_popped_priority,
   output logic [7:0] rsp_popped_score,
   output logic [7:0] rsp_least_score,
   output logic       rsp_queue_empty,
   output logic [1:0] rsp_status
);
   import arqs_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SORT = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] count_ff, count_in;
   logic          post_ff, post_in;
   logic [2:0]    cmd_ff, cmd_in;
   entry_type     new_ff, new_in;
   logic          pend_valid_ff, pend_valid_in;
   entry_type     pend_entry_ff, pend_entry_in;
   logic [1:0]    pend_status_ff, pend_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_popped_valid_ff, rsp_popped_valid_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [7:0]    rsp_least_ff, rsp_least_in;
   logic          rsp_empty_ff, rsp_empty_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   entry_type     entry_w  [QUEUE_DEPTH];
   logic [7:0]    min_w    [QUEUE_DEPTH];
   logic          hit_w    [QUEUE_DEPTH];
   logic          before_w [QUEUE_DEPTH];
   cell_ctl_type  ctl_w    [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] swap_w;
   entry_type     picked;
   entry_type     cell_new;
   logic          full;
   logic          empty;
   logic          found;
   logic          cnt_last;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign found     = hit_w[QUEUE_DEPTH-1];
   assign cnt_last  = cnt_ff == CW'(QUEUE_DEPTH - 1);
   assign cell_new  = (cmd_ff == CMD_PROMOTE) ? picked : new_ff;
   assign req_ready = state_ff == S_IDLE;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_popped_valid    = rsp_popped_valid_ff;
   assign rsp_popped_tag      = rsp_entry_ff.tag;
   assign rsp_popped_priority = rsp_entry_ff.prio;
   assign rsp_popped_score    = rsp_entry_ff.score;
   assign rsp_least_score     = rsp_least_ff;
   assign rsp_queue_empty     = rsp_empty_ff;
   assign rsp_status          = rsp_status_ff;

   generate
      for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         entry_type  left_e;
         entry_type  right_e;
         logic [7:0] min_prev;
         logic       seen_prev;
         if (g == 0) begin : g_first
            assign left_e    = cell_new;
            assign min_prev  = 8'hFF;
            assign seen_prev = 1'b0;
         end else begin : g_rest
            assign left_e    = entry_w[g-1];
            assign min_prev  = min_w[g-1];
            assign seen_prev = hit_w[g-1];
         end
         if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_e = entry_w[g];
         end else begin : g_inner
            assign right_e = entry_w[g+1];
         end
         arqs_cell u_cell (
            .clock        (clock),
            .ctl          (ctl_w[g]),
            .new_entry    (cell_new),
            .left_entry   (left_e),
            .right_entry  (right_e),
            .target_score (new_ff.score),
            .min_in       (min_prev),
            .seen_in      (seen_prev),
            .entry        (entry_w[g]),
            .min_out      (min_w[g]),
            .hit_out      (hit_w[g]),
            .before_out   (before_w[g])
         );
      end
   endgenerate

   // Bit k flags a swap of the pair made of cells k-1 and k.
   always_comb begin
      swap_w = '0;
      for (int k = 1; k < QUEUE_DEPTH; k++) begin
         swap_w[k] = (state_ff == S_SORT) && (1'(k - 1) == cnt_ff[0]) &&
                     (CW'(k) < count_ff) && goes_after(entry_w[k-1], entry_w[k]);
      end
   end

   always_comb begin
      picked = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (hit_w[i] && !before_w[i]) begin
            picked = entry_type'(picked | entry_w[i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ctl_w[i].occupied = CW'(i) < count_ff;
         ctl_w[i].sel      = SEL_HOLD;
         if (state_ff == S_SORT) begin
            if (swap_w[i+1]) begin
               ctl_w[i].sel = SEL_RIGHT;
            end else if (swap_w[i]) begin
               ctl_w[i].sel = SEL_LEFT;
            end
         end else if (state_ff == S_EXEC) begin
            case (cmd_ff)
               CMD_ADD_TAIL: begin
                  if (!full && (CW'(i) == count_ff)) begin
                     ctl_w[i].sel = SEL_NEW;
                  end
               end
               CMD_ADD_HEAD: begin
                  if (!full) begin
                     ctl_w[i].sel = (i == 0) ? SEL_NEW : SEL_LEFT;
                  end
               end
               CMD_POP_HEAD, CMD_POP_SHORT: begin
                  if (!empty) begin
                     ctl_w[i].sel = SEL_RIGHT;
                  end
               end
               CMD_AGE: begin
                  ctl_w[i].sel = SEL_AGE;
               end
               CMD_PROMOTE: begin
                  if (found) begin
                     if (i == 0) begin
                        ctl_w[i].sel = SEL_NEW;
                     end else if (!before_w[i]) begin
                        ctl_w[i].sel = SEL_LEFT;
                     end
                  end
               end
               default: ctl_w[i].sel = SEL_HOLD;
            endcase
         end
      end
   end

   always_comb begin
      state_in            = state_ff;
      cnt_in              = cnt_ff;
      count_in            = count_ff;
      post_in             = post_ff;
      cmd_in              = cmd_ff;
      new_in              = new_ff;
      pend_valid_in       = pend_valid_ff;
      pend_entry_in       = pend_entry_ff;
      pend_status_in      = pend_status_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_popped_valid_in = rsp_popped_valid_ff;
      rsp_entry_in        = rsp_entry_ff;
      rsp_least_in        = rsp_least_ff;
      rsp_empty_in        = rsp_empty_ff;
      rsp_status_in       = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in       = req_command;
               new_in.tag   = req_entry_tag;
               new_in.prio  = req_entry_priority;
               new_in.score = req_score_value;
               cnt_in       = '0;
               post_in      = 1'b0;
               if ((req_command == CMD_POP_SHORT) && !empty) begin
                  state_in = S_SORT;
               end else if (req_command == CMD_PROMOTE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SORT: begin
            cnt_in = CW'(cnt_ff + 1'b1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            cnt_in = CW'(cnt_ff + 1'b1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = post_ff ? S_DONE : S_EXEC;
            end
         end
         S_EXEC: begin
            pend_valid_in  = 1'b0;
            pend_entry_in  = '0;
            pend_status_in = ST_OK;
            case (cmd_ff)
               CMD_ADD_TAIL, CMD_ADD_HEAD: begin
                  if (full) begin
                     pend_status_in = ST_FULL;
                  end else begin
                     count_in = CW'(count_ff + 1'b1);
                  end
               end
               CMD_POP_HEAD, CMD_POP_SHORT: begin
                  if (empty) begin
                     pend_status_in = ST_EMPTY;
                  end else begin
                     pend_valid_in = 1'b1;
                     pend_entry_in = entry_w[0];
                     count_in      = CW'(count_ff - 1'b1);
                  end
               end
               CMD_PROMOTE: begin
                  if (!found) begin
                     pend_status_in = ST_MISS;
                  end
               end
               default: pend_status_in = ST_OK;
            endcase
            post_in  = 1'b1;
            cnt_in   = '0;
            state_in = S_SCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_popped_valid_in = pend_valid_ff;
               rsp_entry_in        = pend_entry_ff;
               rsp_least_in        = min_w[QUEUE_DEPTH-1];
               rsp_empty_in        = empty;
               rsp_status_in       = pend_status_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff              <= cnt_in;
      post_ff             <= post_in;
      cmd_ff              <= cmd_in;
      new_ff              <= new_in;
      pend_valid_ff       <= pend_valid_in;
      pend_entry_ff       <= pend_entry_in;
      pend_status_ff      <= pend_status_in;
      rsp_popped_valid_ff <= rsp_popped_valid_in;
      rsp_entry_ff        <= rsp_entry_in;
      rsp_least_ff        <= rsp_least_in;
      rsp_empty_ff        <= rsp_empty_in;
      rsp_status_ff       <= rsp_status_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_empty_least: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_empty) |-> (rsp_least_score == 8'hFF))
      else $error("An empty queue reported a least score other than 255.");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_popped_valid) |-> (rsp_status == ST_OK))
      else $error("A popped entry came with an error status.");

   a_add_tail_grows: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXEC) && (cmd_ff == CMD_ADD_TAIL) && !full)
      |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("An add at the tail did not grow the queue by one.");

endmodule
